FILE: hw/rtl/dmc_pkg.sv
// Shared constants and types for the direct-mapped write-back cache.
// Used by the channel interfaces, the front and back ends, the top level and the checker.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int ADDR_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int RESULT_LINE_W = 64;

  localparam int LINE_COUNT_DEF   = 64;
  localparam int LINE_BYTES_DEF   = 8;
  localparam int STORE_BLOCKS_DEF = 8192;

  // depth of the queue between front and back, a power of two
  localparam int Q_DEPTH = 2;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              is_write;
    logic [BYTE_W-1:0] wbyte;
  } req_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } fq_t;

  // back end status toward the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_t;

endpackage

FILE: hw/rtl/dmc_in_if.sv
// Access channel: valid/ready handshake carrying one access word.
// Depends on dmc_pkg for field widths.
`timescale 1ns / 1ps

interface dmc_in_if;
  import dmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_address;
  logic              opcode;
  logic [BYTE_W-1:0] write_byte;

  modport source (output valid, access_address, opcode, write_byte, input ready);
  modport sink   (input valid, access_address, opcode, write_byte, output ready);
endinterface

FILE: hw/rtl/dmc_out_if.sv
// Result channel: valid/ready handshake carrying one read result word.
// Depends on dmc_pkg for field widths.
`timescale 1ns / 1ps

interface dmc_out_if;
  import dmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        echo_address;
  logic [RESULT_LINE_W-1:0] line_bytes;
  logic                     was_hit;
  logic                     was_dirty;

  modport source (output valid, echo_address, line_bytes, was_hit, was_dirty, input ready);
  modport sink   (input valid, echo_address, line_bytes, was_hit, was_dirty, output ready);
endinterface

FILE: hw/rtl/dmc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/dmc_front.sv
// Front end: accepts access words, classifies the opcode and queues them for the back end.
// Depends on dmc_pkg and dmc_in_if.
`timescale 1ns / 1ps

module dmc_front (
  input  logic          clk,
  input  logic          rst_n,
  dmc_in_if.sink        in_ch,
  output dmc_pkg::fq_t  fq,
  input  dmc_pkg::bk_t  bk
);
  import dmc_pkg::*;

  localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  req_t            q_mem_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt;
  logic [QP_W-1:0] rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            full;
  logic            push;
  req_t            req_in;

  assign full        = (cnt_r == QC_W'(Q_DEPTH));
  assign in_ch.ready = !full && !bk.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign req_in.addr     = in_ch.access_address;
  assign req_in.is_write = (in_ch.opcode == OP_WRITE);
  assign req_in.wbyte    = in_ch.write_byte;

  always_comb begin
    wp_nxt  = push   ? wp_r + QP_W'(1) : wp_r;
    rp_nxt  = bk.pop ? rp_r + QP_W'(1) : rp_r;
    cnt_nxt = cnt_r + QC_W'(push) - QC_W'(bk.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= req_in;
    end
  end

  assign fq.valid = (cnt_r != '0);
  assign fq.req   = q_mem_r[rp_r];

endmodule

FILE: hw/rtl/dmc_back.sv
// Back end: sequencer that zeroes both RAMs, looks up the cache RAM, writes back,
// refills from the backing store RAM, updates the line and drives the result
// register. Depends on dmc_pkg, dmc_out_if and dmc_ram.
`timescale 1ns / 1ps

module dmc_back #(
  parameter int LINE_COUNT   = dmc_pkg::LINE_COUNT_DEF,
  parameter int LINE_BYTES   = dmc_pkg::LINE_BYTES_DEF,
  parameter int STORE_BLOCKS = dmc_pkg::STORE_BLOCKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dmc_pkg::fq_t  fq,
  output dmc_pkg::bk_t  bk,
  dmc_out_if.source     out_ch
);
  import dmc_pkg::*;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int IDX_W   = $clog2(LINE_COUNT);
  localparam int TAG_RAW = ADDR_W - OFF_W - IDX_W;
  localparam int TAG_W   = (TAG_RAW < 1) ? 1 : TAG_RAW;
  localparam int BLK_W   = ADDR_W - OFF_W;
  localparam int SA_W    = $clog2(STORE_BLOCKS);
  localparam int LW      = LINE_BYTES * BYTE_W;
  // cache word: dirty mark, tag, line bytes
  localparam int CW      = 1 + TAG_W + LW;
  localparam int CLR_N   = (STORE_BLOCKS > LINE_COUNT) ? STORE_BLOCKS : LINE_COUNT;
  localparam int CLR_W   = $clog2(CLR_N);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_RD    = 5'b01000,
    S_FILL  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  req_t                     cur_r, cur_nxt;
  logic [CLR_W-1:0]         clr_r, clr_nxt;

  logic                     out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]        out_addr_r;
  logic [RESULT_LINE_W-1:0] out_line_r;
  logic                     out_hit_r;
  logic                     out_dirty_r;
  logic                     out_load;

  logic [OFF_W-1:0]         cur_off;
  logic [IDX_W-1:0]         cur_idx;
  logic [TAG_W-1:0]         cur_tag;
  logic [BLK_W-1:0]         cur_blk;

  logic                     c_we, c_re;
  logic [IDX_W-1:0]         c_waddr, c_raddr;
  logic [CW-1:0]            c_wdata, c_rdata;
  logic [TAG_W-1:0]         c_tag;
  logic [LW-1:0]            c_data;

  logic                     s_we, s_re;
  logic [SA_W-1:0]          s_waddr, s_raddr;
  logic [LW-1:0]            s_wdata, s_rdata;

  logic                     hit;
  logic                     cur_dirty;
  logic                     out_free;
  logic                     finish;
  logic                     pop;
  logic [LW-1:0]            base;
  logic [LW-1:0]            merged;

  assign cur_off = OFF_W'(cur_r.addr);
  assign cur_idx = IDX_W'(cur_r.addr >> OFF_W);
  assign cur_tag = TAG_W'(cur_r.addr >> (OFF_W + IDX_W));
  assign cur_blk = BLK_W'(cur_r.addr >> OFF_W);

  assign cur_dirty = c_rdata[CW-1];
  assign c_tag     = c_rdata[CW-2 -: TAG_W];
  assign c_data    = c_rdata[LW-1:0];
  assign hit       = (c_tag == cur_tag);
  assign out_free  = !out_v_r || out_ch.ready;
  assign base      = state_r[4] ? s_rdata : c_data;

  always_comb begin
    for (int b = 0; b < LINE_BYTES; b++) begin
      merged[b*BYTE_W +: BYTE_W] = (cur_off == OFF_W'(b)) ? cur_r.wbyte
                                                        : base[b*BYTE_W +: BYTE_W];
    end
  end

  // access completes once the line is in hand and a read has room for its result
  assign finish = ((state_r == S_LOOK && hit) || state_r == S_FILL) &&
                  (cur_r.is_write || out_free);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    clr_nxt   = clr_r;
    pop       = 1'b0;
    c_we      = 1'b0;
    c_waddr   = cur_idx;
    // a write marks the line dirty, a refill clears it, a read hit keeps it
    c_wdata   = {cur_r.is_write || (cur_dirty && !state_r[4]), cur_tag,
                 cur_r.is_write ? merged : base};
    c_re      = 1'b0;
    c_raddr   = IDX_W'(fq.req.addr >> OFF_W);
    s_we      = 1'b0;
    s_waddr   = SA_W'({{SA_W{1'b0}}, c_tag, cur_idx});
    s_wdata   = c_data;
    s_re      = 1'b0;
    s_raddr   = SA_W'({{SA_W{1'b0}}, cur_blk});
    out_load  = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // zero both memories, one entry of each per cycle
        c_we    = 1'b1;
        c_waddr = clr_r[IDX_W-1:0];
        c_wdata = '0;
        s_we    = 1'b1;
        s_waddr = clr_r[SA_W-1:0];
        s_wdata = '0;
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (fq.valid) begin
          pop       = 1'b1;
          cur_nxt   = fq.req;
          c_re      = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!hit) begin
          s_we      = cur_dirty;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        s_re      = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      c_we      = 1'b1;
      out_load  = !cur_r.is_write;
      state_nxt = S_IDLE;
    end
  end

  assign out_v_nxt = out_load || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (out_load) begin
      out_addr_r  <= cur_r.addr;
      out_line_r  <= RESULT_LINE_W'({{RESULT_LINE_W{1'b0}}, base});
      out_hit_r   <= state_r[2];
      out_dirty_r <= cur_dirty;
    end
  end

  dmc_ram #(.WIDTH(CW), .DEPTH(LINE_COUNT)) u_cache_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  dmc_ram #(.WIDTH(LW), .DEPTH(STORE_BLOCKS)) u_store_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign bk.pop      = pop;
  assign bk.clearing = state_r[0];

  assign out_ch.valid        = out_v_r;
  assign out_ch.echo_address = out_addr_r;
  assign out_ch.line_bytes   = out_line_r;
  assign out_ch.was_hit      = out_hit_r;
  assign out_ch.was_dirty    = out_dirty_r;

endmodule

FILE: hw/rtl/direct_mapped_writeback_cache_core.sv
// Direct-mapped write-back cache with its backing store, both held in on-chip RAM.
// in_ch carries one access word (address, opcode, write byte); out_ch returns one word
// per read: the address, the line after the access, the hit flag and the old dirty flag.
// Writes return nothing. Both channels are valid/ready; a word moves when both are high.
// Accesses are handled one at a time by the single back-end sequencer: a registered
// cache RAM read, then on a miss a write-back and a registered backing-store read
// before the line is updated.
// A two-entry queue sits between the accepting front and the back end, so accesses are
// still taken while the back end works or while a result waits in the output register.
// When the receiver stalls the result register holds and the back end waits once it
// has another read to return; the front keeps taking words until the queue is full.
// After reset the cache and store RAMs are zeroed in a clearing pass that steps through
// every entry of both, during which in_ch.ready is low. The user must keep LINE_COUNT,
// LINE_BYTES and STORE_BLOCKS powers of two; the block itself does not enforce it.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_core #(
  parameter int LINE_COUNT   = dmc_pkg::LINE_COUNT_DEF,
  parameter int LINE_BYTES   = dmc_pkg::LINE_BYTES_DEF,
  parameter int STORE_BLOCKS = dmc_pkg::STORE_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dmc_in_if.sink    in_ch,
  dmc_out_if.source out_ch
);
  import dmc_pkg::*;

  fq_t fq;
  bk_t bk;

  dmc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .fq    (fq),
    .bk    (bk)
  );

  dmc_back #(
    .LINE_COUNT   (LINE_COUNT),
    .LINE_BYTES   (LINE_BYTES),
    .STORE_BLOCKS (STORE_BLOCKS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .fq     (fq),
    .bk     (bk),
    .out_ch (out_ch)
  );

endmodule

FILE: hw/rtl/dmc_checker.sv
// Port-level checker for the cache core, attached to the top level by bind.
// Depends on dmc_pkg and direct_mapped_writeback_cache_core.
`timescale 1ns / 1ps

module dmc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_opcode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [dmc_pkg::ADDR_W-1:0]        out_echo_address,
  input logic [dmc_pkg::RESULT_LINE_W-1:0] out_line_bytes,
  input logic                              out_was_hit,
  input logic                              out_was_dirty
);
  import dmc_pkg::*;

  // reads accepted whose result word has not been taken yet
  logic [2:0] pend_r, pend_nxt;
  logic       rd_in, rd_out;

  assign rd_in    = in_valid && in_ready && (in_opcode == OP_READ);
  assign rd_out   = out_valid && out_ready;
  assign pend_nxt = pend_r + 3'(rd_in) - 3'(rd_out);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_echo_address) &&
      $stable(out_line_bytes) && $stable(out_was_hit) && $stable(out_was_dirty))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channels active right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result word without an outstanding read");

endmodule

bind direct_mapped_writeback_cache_core dmc_checker u_dmc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_opcode        (in_ch.opcode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_echo_address (out_ch.echo_address),
  .out_line_bytes   (out_ch.line_bytes),
  .out_was_hit      (out_ch.was_hit),
  .out_was_dirty    (out_ch.was_dirty)
);

FILE: tb/direct_mapped_writeback_cache_core_tb.sv
// Testbench for direct_mapped_writeback_cache_core: directed and random access traffic,
// each read word checked against a shadow cache and backing store kept here.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if and the core itself.
`timescale 1ns / 1ps

module direct_mapped_writeback_cache_core_tb;
  import dmc_pkg::*;

  localparam int OFF_W  = $clog2(LINE_BYTES_DEF);
  localparam int IDX_W  = $clog2(LINE_COUNT_DEF);
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int BLK_W  = $clog2(STORE_BLOCKS_DEF);
  localparam int LINE_W = 8 * LINE_BYTES_DEF;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [RESULT_LINE_W-1:0] data;
    logic                     hit;
    logic                     dirty;
  } read_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dmc_in_if  in_ch();
  dmc_out_if out_ch();

  direct_mapped_writeback_cache_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the cache and its backing store
  logic [TAG_W-1:0]  shadow_tag   [LINE_COUNT_DEF];
  logic              shadow_dirty [LINE_COUNT_DEF];
  logic [LINE_W-1:0] shadow_line  [LINE_COUNT_DEF];
  logic [LINE_W-1:0] shadow_mem   [STORE_BLOCKS_DEF];

  read_word_t pending_reads[$];

  int gap_max   = 0;
  int stall_max = 0;
  int fail_count = 0;
  int n_reads, n_writes, n_hits, n_misses, n_evicts, n_checked;

  logic [TAG_W-1:0] tag_pool  [4];
  logic [IDX_W-1:0] line_pool [8];

  // update the shadow state for one access; queue the read word it returns
  task automatic apply_access(input logic [ADDR_W-1:0] addr, input logic op,
                              input logic [BYTE_W-1:0] wbyte);
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    logic [OFF_W-1:0] off;
    logic             hit;
    logic             was_dirty;
    read_word_t       rw;
    idx = addr[OFF_W +: IDX_W];
    tg  = addr[ADDR_W-1 -: TAG_W];
    off = addr[OFF_W-1:0];
    hit = (shadow_tag[idx] == tg);
    was_dirty = shadow_dirty[idx];
    if (hit) n_hits++; else n_misses++;
    if (!hit) begin
      if (shadow_dirty[idx]) begin
        shadow_mem[BLK_W'({shadow_tag[idx], idx})] = shadow_line[idx];
        n_evicts++;
      end
      shadow_line[idx]  = shadow_mem[BLK_W'(addr[ADDR_W-1:OFF_W])];
      shadow_tag[idx]   = tg;
      shadow_dirty[idx] = 1'b0;
    end
    if (op == OP_WRITE) begin
      shadow_line[idx][8*off +: 8] = wbyte;
      shadow_dirty[idx] = 1'b1;
      n_writes++;
    end else begin
      rw.addr  = addr;
      rw.data  = RESULT_LINE_W'(shadow_line[idx]);
      rw.hit   = hit;
      rw.dirty = was_dirty;
      pending_reads.push_back(rw);
      n_reads++;
    end
  endtask

  // called at a rising edge; returns at the edge where the word was taken
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic op,
                             input logic [BYTE_W-1:0] wbyte);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.access_address <= addr;
    in_ch.opcode         <= op;
    in_ch.write_byte     <= wbyte;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    apply_access(addr, op, wbyte);
  endtask

  // hold off new words until every read word has come back or the bound runs out
  task automatic wait_for_reads(input int bound);
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (pending_reads.size() != 0 && n < bound);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    a = ADDR_W'($urandom_range(0, 65535));
    // mostly aim at a few lines and tags so hits and dirty evictions are common
    if ($urandom_range(0, 99) < 65) begin
      a[ADDR_W-1 -: TAG_W] = tag_pool[$urandom_range(0, 3)];
      a[OFF_W +: IDX_W]    = line_pool[$urandom_range(0, 7)];
    end
    return a;
  endfunction

  task automatic refresh_pools();
    for (int i = 0; i < 4; i++) tag_pool[i] = TAG_W'($urandom_range(0, 127));
    for (int i = 0; i < 8; i++) line_pool[i] = IDX_W'($urandom_range(0, 63));
    if ($urandom_range(0, 1) == 1) tag_pool[0] = '0;
  endtask

  task automatic test_first_use();
    send_access(16'h0000, OP_READ, 8'h00);
    send_access(16'hFFFF, OP_READ, 8'hFF);
    send_access(16'h01F8, OP_READ, 8'h00);
  endtask

  task automatic test_write_then_read();
    send_access(16'h0007, OP_WRITE, 8'hFF);
    send_access(16'h0000, OP_WRITE, 8'hA5);
    send_access(16'h0003, OP_WRITE, 8'h00);
    send_access(16'h0003, OP_READ, 8'h5A);
  endtask

  task automatic test_dirty_victim();
    // evict the dirty line 0, then bring block 0 back from the store
    send_access(16'hFE00, OP_READ, 8'h00);
    send_access(16'h0001, OP_READ, 8'h00);
    send_access(16'hFE06, OP_WRITE, 8'h81);
    send_access(16'h0000, OP_WRITE, 8'h7E);
    send_access(16'hFE07, OP_READ, 8'h00);
  endtask

  task automatic test_write_miss();
    send_access(16'h1234, OP_WRITE, 8'h5A);
    send_access(16'h1230, OP_READ, 8'h00);
    send_access(16'h5234, OP_READ, 8'h00);
    send_access(16'h1237, OP_READ, 8'h00);
    send_access(16'hFFF8, OP_WRITE, 8'h01);
    send_access(16'h7FFF, OP_READ, 8'h00);
    send_access(16'hFFFF, OP_READ, 8'h00);
  endtask

  task automatic test_random_traffic(input int count, input int gmax, input int smax);
    gap_max   = gmax;
    stall_max = smax;
    refresh_pools();
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 99) refresh_pools();
      send_access(pick_address(), $urandom_range(0, 1) ? OP_WRITE : OP_READ,
                  BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_read_burst_backpressure();
    gap_max   = 0;
    stall_max = 4;
    refresh_pools();
    for (int i = 0; i < 100; i++)
      send_access(pick_address(), OP_READ, BYTE_W'($urandom_range(0, 255)));
  endtask

  // result side: stall at random, check each word at the cycle it moves
  initial begin
    int stall;
    read_word_t got, want;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
      while (out_ch.valid !== 1'b1) @(negedge clk);
      got.addr  = out_ch.echo_address;
      got.data  = out_ch.line_bytes;
      got.hit   = out_ch.was_hit;
      got.dirty = out_ch.was_dirty;
      if (pending_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected read word addr=%h line=%h hit=%b dirty=%b",
                   got.addr, got.data, got.hit, got.dirty);
      end else begin
        want = pending_reads.pop_front();
        n_checked++;
        if (got.addr !== want.addr || got.data !== want.data ||
            got.hit !== want.hit || got.dirty !== want.dirty) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: read word mismatch: exp addr=%h line=%h hit=%b dirty=%b, got addr=%h line=%h hit=%b dirty=%b",
                     want.addr, want.data, want.hit, want.dirty,
                     got.addr, got.data, got.hit, got.dirty);
        end
      end
      @(posedge clk);
    end
  end

  initial begin
    #3_000_000;
    $display("direct_mapped_writeback_cache_core verification failed");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.access_address = '0;
    in_ch.opcode         = OP_READ;
    in_ch.write_byte     = '0;
    for (int i = 0; i < LINE_COUNT_DEF; i++) begin
      shadow_tag[i]   = '0;
      shadow_dirty[i] = 1'b0;
      shadow_line[i]  = '0;
    end
    for (int i = 0; i < STORE_BLOCKS_DEF; i++) shadow_mem[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_use();
    test_write_then_read();
    gap_max   = 4;
    stall_max = 4;
    test_dirty_victim();
    test_write_miss();

    test_random_traffic(400, 4, 4);
    wait_for_reads(5000);
    test_random_traffic(250, 0, 0);
    test_read_burst_backpressure();
    test_random_traffic(200, 4, 0);
    test_random_traffic(250, 0, 4);

    wait_for_reads(5000);
    repeat (16) @(posedge clk);
    if (pending_reads.size() != 0) begin
      fail_count += pending_reads.size();
      $display("ERROR: %0d read words never returned", pending_reads.size());
    end
    $display("Covered %0d reads (%0d checked) and %0d writes: %0d hits, %0d misses,",
             n_reads, n_checked, n_writes, n_hits, n_misses);
    $display("%0d dirty write-backs, with random gaps and stalls on both sides; %0d errors",
             n_evicts, fail_count);
    if (fail_count == 0) begin
      $display("direct_mapped_writeback_cache_core verification clean");
    end else begin
      $display("direct_mapped_writeback_cache_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_in_if.sv
hw/rtl/dmc_out_if.sv
hw/rtl/dmc_ram.sv
hw/rtl/dmc_front.sv
hw/rtl/dmc_back.sv
hw/rtl/direct_mapped_writeback_cache_core.sv
hw/rtl/dmc_checker.sv
tb/direct_mapped_writeback_cache_core_tb.sv
